[design/kmrb_pkg.sv]
// Shared types and constants for the key matrix report builder.
// No dependencies; used by kmrb_key_store and key_matrix_report_builder_top.
package kmrb_pkg;

   localparam int REPORT_SLOTS = 6;
   localparam int KEY_IDX_W    = 6;
   localparam int CODE_W       = 8;
   localparam int CNT_W        = 4;

   typedef enum logic {
      OP_SCAN        = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } kmrb_op_type;

   typedef enum logic {
      REG_RELEASE_SCANS = 1'b0,
      REG_RESET_CODE    = 1'b1
   } kmrb_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } kmrb_state_type;

   // Key table entry; bit order matches normal code in the low byte.
   typedef struct packed {
      logic              is_layer_key;
      logic              is_modifier;
      logic [CODE_W-1:0] alternate_code;
      logic [CODE_W-1:0] normal_code;
   } kmrb_entry_type;

   typedef struct packed {
      logic                 tbl_we;
      logic [KEY_IDX_W-1:0] tbl_addr;
      kmrb_entry_type       tbl_data;
      logic                 rd_en;
      logic [KEY_IDX_W-1:0] rd_addr;
      logic                 cnt_we;
      logic [KEY_IDX_W-1:0] cnt_addr;
      logic [CNT_W-1:0]     cnt_data;
   } kmrb_store_cmd_type;

   typedef struct packed {
      logic [CODE_W-1:0]                   modifier;
      logic [REPORT_SLOTS-1:0][CODE_W-1:0] codes;
      logic                                boot;
   } kmrb_report_type;

endpackage

[design/kmrb_key_store.sv]
// Per-key storage: key table memory and release countdown memory.
// Depends on kmrb_pkg. Countdown entries read as zero until first written.
module kmrb_key_store #(
   parameter int NUM_KEYS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kmrb_pkg::kmrb_store_cmd_type cmd,
   output kmrb_pkg::kmrb_entry_type     tbl_q,
   output logic [kmrb_pkg::CNT_W-1:0]   cnt_q
);
   import kmrb_pkg::*;

   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   kmrb_entry_type   tbl_mem [NUM_KEYS];
   logic [CNT_W-1:0] cnt_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] cnt_vld_ff;
   kmrb_entry_type   tbl_q_ff;
   logic [CNT_W-1:0] cnt_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.tbl_we) begin
         tbl_mem[cmd.tbl_addr[KEY_W-1:0]] <= cmd.tbl_data;
      end
      if (cmd.cnt_we) begin
         cnt_mem[cmd.cnt_addr[KEY_W-1:0]] <= cmd.cnt_data;
      end
      if (cmd.rd_en) begin
         tbl_q_ff <= tbl_mem[cmd.rd_addr[KEY_W-1:0]];
         cnt_q_ff <= cnt_vld_ff[cmd.rd_addr[KEY_W-1:0]] ?
                     cnt_mem[cmd.rd_addr[KEY_W-1:0]] : '0;
      end
   end

   // one valid bit per countdown entry stands in for a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (cmd.cnt_we) begin
         cnt_vld_ff[cmd.cnt_addr[KEY_W-1:0]] <= 1'b1;
      end
   end

   assign tbl_q = tbl_q_ff;
   assign cnt_q = cnt_q_ff;

endmodule

[design/key_matrix_report_builder_top.sv]
// Keyboard report builder top level: six-slot report with release countdown.
// Scan: keys are walked one per cycle through the key store read port, except while
// the walk holds because a new report waits for the result side to take the held one.
// Up to NUM_KEYS reports per scan, the last marked.
// Synchronous reset clears slots, modifiers, pressed history and countdowns;
// the key table is undefined until written.
module key_matrix_report_builder_top #(
   parameter int NUM_KEYS  = 64,
   parameter int NUM_SLOTS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_scan_bits,
   input  logic [5:0]  req_entry_key,
   input  logic [7:0]  req_normal_code,
   input  logic [7:0]  req_alternate_code,
   input  logic        req_is_modifier,
   input  logic        req_is_layer_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_modifier_bits,
   output logic [7:0]  rsp_slot_code_0,
   output logic [7:0]  rsp_slot_code_1,
   output logic [7:0]  rsp_slot_code_2,
   output logic [7:0]  rsp_slot_code_3,
   output logic [7:0]  rsp_slot_code_4,
   output logic [7:0]  rsp_slot_code_5,
   output logic        rsp_boot_request,
   output logic        rsp_last_report,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kmrb_pkg::*;

   localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int ITER_W = $clog2(NUM_KEYS + 1);

   // configuration
   logic [CNT_W-1:0]  rel_scans_ff;
   logic [CODE_W-1:0] reset_code_ff;

   kmrb_state_type state_ff, state_in;
   logic [ITER_W-1:0] iss_ff, iss_in;
   logic              p_vld_ff, p_vld_in;
   logic [KEY_W-1:0]  p_key_ff, p_key_in;
   logic [NUM_KEYS-1:0] now_ff, now_in;
   logic [NUM_KEYS-1:0] prev_ff, prev_in;
   logic [NUM_KEYS-1:0] layer_ff, layer_in;
   logic              shift_ff, shift_in;
   logic [CODE_W-1:0] mod_ff, mod_in;
   logic [REPORT_SLOTS-1:0]                 slot_valid_ff, slot_valid_in;
   logic [REPORT_SLOTS-1:0][KEY_IDX_W-1:0]  slot_owner_ff, slot_owner_in;
   logic [REPORT_SLOTS-1:0][CODE_W-1:0]     slot_code_ff, slot_code_in;
   kmrb_report_type   pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   kmrb_report_type   out_ff, out_in;
   logic              out_last_ff, out_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   kmrb_store_cmd_type cmd;
   kmrb_entry_type     tbl_q;
   logic [CNT_W-1:0]   cnt_q;

   logic              down, was, is_press, is_rel, is_removal, emit;
   logic              out_free, advance, can_issue, key_ok;
   logic [CODE_W-1:0] code;
   logic [KEY_IDX_W-1:0] key6;

   kmrb_key_store #(
      .NUM_KEYS (NUM_KEYS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .tbl_q (tbl_q),
      .cnt_q (cnt_q)
   );

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_scans_ff  <= CNT_W'(7);
         reset_code_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (kmrb_reg_type'(csr_paddr[2]))
            REG_RELEASE_SCANS: rel_scans_ff  <= csr_pwdata[CNT_W-1:0];
            REG_RESET_CODE:    reset_code_ff <= csr_pwdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (kmrb_reg_type'(csr_paddr[2]))
         REG_RELEASE_SCANS: csr_prdata = {{(32-CNT_W){1'b0}}, rel_scans_ff};
         REG_RESET_CODE:    csr_prdata = {{(32-CODE_W){1'b0}}, reset_code_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------- key evaluation
   assign key6       = KEY_IDX_W'(p_key_ff);
   assign down       = now_ff[p_key_ff];
   assign was        = prev_ff[p_key_ff];
   assign code       = shift_ff ? tbl_q.alternate_code : tbl_q.normal_code;
   assign is_press   = down && !was;
   assign is_rel     = !down && was;
   assign is_removal = !is_press && !is_rel && (cnt_q == CNT_W'(1));
   assign emit       = p_vld_ff && (is_press || is_removal);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // a new report needs the held one moved to the output register first
   assign advance    = !(emit && pend_vld_ff && !out_free);
   assign can_issue  = iss_ff < ITER_W'(NUM_KEYS);
   assign key_ok     = {1'b0, req_entry_key} < 7'(NUM_KEYS);
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      logic held;
      logic found;
      logic boot;

      held          = 1'b0;
      found         = 1'b0;
      boot          = 1'b0;
      state_in      = state_ff;
      iss_in        = iss_ff;
      p_vld_in      = p_vld_ff;
      p_key_in      = p_key_ff;
      now_in        = now_ff;
      prev_in       = prev_ff;
      layer_in      = layer_ff;
      shift_in      = shift_ff;
      mod_in        = mod_ff;
      slot_valid_in = slot_valid_ff;
      slot_owner_in = slot_owner_ff;
      slot_code_in  = slot_code_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (kmrb_op_type'(req_opcode) == OP_TABLE_WRITE) begin
                  if (key_ok) begin
                     cmd.tbl_we   = 1'b1;
                     cmd.tbl_addr = req_entry_key;
                     cmd.tbl_data = '{is_layer_key:   req_is_layer_key,
                                      is_modifier:    req_is_modifier,
                                      alternate_code: req_alternate_code,
                                      normal_code:    req_normal_code};
                     layer_in[req_entry_key[KEY_W-1:0]] = req_is_layer_key;
                  end
               end else begin
                  now_in   = req_scan_bits[NUM_KEYS-1:0];
                  shift_in = |(req_scan_bits[NUM_KEYS-1:0] & layer_ff);
                  iss_in   = '0;
                  p_vld_in = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (advance) begin
               if (can_issue) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = KEY_IDX_W'(iss_ff[KEY_W-1:0]);
                  p_vld_in    = 1'b1;
                  p_key_in    = iss_ff[KEY_W-1:0];
                  iss_in      = iss_ff + ITER_W'(1);
               end else begin
                  p_vld_in = 1'b0;
                  prev_in  = now_ff;
                  state_in = ST_FLUSH;
               end

               if (p_vld_ff) begin
                  cmd.cnt_addr = key6;
                  if (is_press) begin
                     cmd.cnt_we   = 1'b1;
                     cmd.cnt_data = '0;
                     if (reset_code_ff != '0 && code == reset_code_ff) begin
                        boot = 1'b1;
                     end else if (tbl_q.is_modifier) begin
                        mod_in = mod_ff | code;
                     end else begin
                        for (int s = 0; s < NUM_SLOTS; s++) begin
                           if (slot_valid_ff[s] && slot_owner_ff[s] == key6) begin
                              held = 1'b1;
                           end
                        end
                        if (!held) begin
                           for (int s = 0; s < NUM_SLOTS; s++) begin
                              if (!found && !slot_valid_ff[s]) begin
                                 found            = 1'b1;
                                 slot_valid_in[s] = 1'b1;
                                 slot_owner_in[s] = key6;
                                 slot_code_in[s]  = code;
                              end
                           end
                        end
                     end
                  end else if (is_rel) begin
                     cmd.cnt_we   = 1'b1;
                     cmd.cnt_data = (rel_scans_ff == '0) ? CNT_W'(1) : rel_scans_ff;
                  end else if (cnt_q != '0) begin
                     cmd.cnt_we   = 1'b1;
                     cmd.cnt_data = cnt_q - CNT_W'(1);
                     if (is_removal) begin
                        if (tbl_q.is_modifier) begin
                           mod_in = mod_ff & ~code;
                        end else begin
                           for (int s = 0; s < NUM_SLOTS; s++) begin
                              if (!found && slot_valid_ff[s] &&
                                  slot_owner_ff[s] == key6) begin
                                 found            = 1'b1;
                                 slot_valid_in[s] = 1'b0;
                                 slot_owner_in[s] = '0;
                                 slot_code_in[s]  = '0;
                              end
                           end
                        end
                     end
                  end

                  if (emit) begin
                     pend_vld_in      = 1'b1;
                     pend_in.modifier = mod_in;
                     pend_in.boot     = boot;
                     for (int s = 0; s < REPORT_SLOTS; s++) begin
                        pend_in.codes[s] = slot_valid_in[s] ? slot_code_in[s] : '0;
                     end
                     if (pend_vld_ff) begin
                        out_in       = pend_ff;
                        out_last_in  = 1'b0;
                        rsp_valid_in = 1'b1;
                     end
                  end
               end
            end
         end

         ST_FLUSH: begin
            // the report still held is the last one of this scan
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in       = pend_ff;
               out_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_ff        <= '0;
         p_vld_ff      <= 1'b0;
         prev_ff       <= '0;
         mod_ff        <= '0;
         slot_valid_ff <= '0;
         slot_owner_ff <= '0;
         slot_code_ff  <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         p_vld_ff      <= p_vld_in;
         prev_ff       <= prev_in;
         mod_ff        <= mod_in;
         slot_valid_ff <= slot_valid_in;
         slot_owner_ff <= slot_owner_in;
         slot_code_ff  <= slot_code_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_key_ff    <= p_key_in;
      now_ff      <= now_in;
      layer_ff    <= layer_in;
      shift_ff    <= shift_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // -------------------------------------------------------------- outputs
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_modifier_bits = out_ff.modifier;
   assign rsp_slot_code_0   = out_ff.codes[0];
   assign rsp_slot_code_1   = out_ff.codes[1];
   assign rsp_slot_code_2   = out_ff.codes[2];
   assign rsp_slot_code_3   = out_ff.codes[3];
   assign rsp_slot_code_4   = out_ff.codes[4];
   assign rsp_slot_code_5   = out_ff.codes[5];
   assign rsp_boot_request  = out_ff.boot;
   assign rsp_last_report   = out_last_ff;

endmodule
